### hw/rtl/prwd_pkg.sv
// ----------------------------------------------------------------------------
// prwd_pkg
// Shared widths, register indexes and types of the pulse rate detector.
// ----------------------------------------------------------------------------
package prwd_pkg;

    localparam int IN_SAMPLE_BITS = 12;
    localparam int THR_BITS       = 12;
    localparam int NUM_BITS       = 16;
    localparam int GAP_BITS       = 6;
    localparam int RATE_BITS      = 16;
    localparam int CFG_ADDR_BITS  = 4;
    localparam int CFG_DATA_BITS  = 32;
    localparam int REG_IDX_BITS   = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_RISE_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_RATE_NUMERATOR = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MIN_GAP        = 2'd2;

    localparam logic [THR_BITS-1:0] RISE_THRESHOLD_RST = 12'd123;
    localparam logic [NUM_BITS-1:0] RATE_NUMERATOR_RST = 16'd1920;
    localparam logic [GAP_BITS-1:0] MIN_GAP_RST        = 6'd10;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

### hw/rtl/prwd_if.sv
// ----------------------------------------------------------------------------
// prwd_sample_if / prwd_result_if
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
interface prwd_sample_if import prwd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [IN_SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface prwd_result_if import prwd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [RATE_BITS-1:0] pulse_rate;
    logic                 rate_updated;

    modport source (output valid, output pulse_rate, output rate_updated, input ready);
    modport sink   (input valid, input pulse_rate, input rate_updated, output ready);
endinterface

### hw/rtl/prwd_divider.sv
// ----------------------------------------------------------------------------
// prwd_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prwd_divider import prwd_pkg::*; #(
    parameter int DEN_BITS = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_numer,
    input  logic [DEN_BITS-1:0] i_denom,
    output t_div_status         o_status,
    output logic [NUM_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(NUM_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DEN_BITS-1:0] r_den;
    logic [DEN_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_q;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                q_bit;

    assign trial = {r_rem, r_q[NUM_BITS-1]};
    assign q_bit = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_denom;
            r_rem <= '0;
            r_q   <= i_numer;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            r_q   <= {r_q[NUM_BITS-2:0], q_bit};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_q;

endmodule

### hw/rtl/pulse_rate_window_detector.sv
// ----------------------------------------------------------------------------
// pulse_rate_window_detector
// Sample window in a circular memory, edge scan and rate division.
// ----------------------------------------------------------------------------
// Each sample beat is written into a WINDOW_DEPTH-entry circular memory. A
// beat that does not start an analysis is answered at once with the held
// rate, so such beats pass at one per cycle while the result register
// drains. Every ANALYSIS_PERIOD-th beat, the first after reset included,
// runs a scan: each scan step reads two window entries from the memory's
// two read ports and evaluates them in the next cycle, and a scan walks
// at most about WINDOW_DEPTH steps, followed by the serial divider (skipped
// for a zero edge distance) and the load of the result. Entries not yet
// written since reset read as zero through a fill count; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module pulse_rate_window_detector import prwd_pkg::*; #(
    parameter int WINDOW_DEPTH    = 64,
    parameter int ANALYSIS_PERIOD = 32,
    parameter int SAMPLE_BITS     = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    prwd_sample_if.sink              i_sample_ch,
    prwd_result_if.source            o_result_ch,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int IW          = $clog2(WINDOW_DEPTH);
    localparam int FW          = $clog2(WINDOW_DEPTH + 1);
    localparam int PW          = $clog2(ANALYSIS_PERIOD + 1);
    localparam int LW          = IW + 2;
    localparam int CW          = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 2;
    localparam int SCAN_LIMIT  = WINDOW_DEPTH - 2;
    localparam int FIRST_LIMIT = WINDOW_DEPTH - 13;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EV   = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [1:0] MD_SKIP1 = 2'd0;
    localparam logic [1:0] MD_FIND1 = 2'd1;
    localparam logic [1:0] MD_SKIP2 = 2'd2;
    localparam logic [1:0] MD_FIND2 = 2'd3;

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW_DEPTH];

    logic [2:0]             r_state, n_state;
    logic [1:0]             r_mode, n_mode;
    logic [IW-1:0]          r_idx, n_idx;
    logic [IW-1:0]          r_first, n_first;
    logic [IW-1:0]          r_wptr;
    logic [FW-1:0]          r_fill;
    logic [PW-1:0]          r_phase;
    logic [RATE_BITS-1:0]   r_held, n_held;
    logic                   r_ov, n_ov;
    logic [RATE_BITS-1:0]   r_o_rate, n_o_rate;
    logic                   r_o_upd, n_o_upd;
    logic [THR_BITS-1:0]    r_thr;
    logic [NUM_BITS-1:0]    r_num;
    logic [GAP_BITS-1:0]    r_gap;
    logic [SAMPLE_BITS-1:0] r_a, r_b;
    logic                   r_av, r_bv;

    logic                   acc;
    logic                   in_rdy;
    logic                   out_free;
    logic                   cfg_wr;
    logic [REG_IDX_BITS-1:0] cfg_idx;
    logic [SAMPLE_BITS+IN_SAMPLE_BITS-1:0] smp_ext;
    logic [SAMPLE_BITS-1:0] smp_k;

    logic                   rd_en;
    logic [IW:0]            idx_b;
    logic [IW:0]            sum_a, sum_b;
    logic [IW-1:0]          addr_a, addr_b;
    logic                   val_a, val_b;
    logic [IW-1:0]          limit;
    logic                   at_limit;
    logic signed [CW-1:0]   a_s, b_s, rise, thr_s;
    logic                   go_on;
    logic [LW-1:0]          last_sum;
    logic [IW-1:0]          last_clamp;
    logic [IW-1:0]          edge_dist;
    logic                   div_start;
    t_div_status            div_st;
    logic [NUM_BITS-1:0]    div_quot;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= RISE_THRESHOLD_RST;
            r_num <= RATE_NUMERATOR_RST;
            r_gap <= MIN_GAP_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RISE_THRESHOLD: r_thr <= pwdata[THR_BITS-1:0];
                REG_RATE_NUMERATOR: r_num <= pwdata[NUM_BITS-1:0];
                REG_MIN_GAP:        r_gap <= pwdata[GAP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RISE_THRESHOLD: prdata = CFG_DATA_BITS'(r_thr);
            REG_RATE_NUMERATOR: prdata = CFG_DATA_BITS'(r_num);
            REG_MIN_GAP:        prdata = CFG_DATA_BITS'(r_gap);
            default:            prdata = '0;
        endcase
    end

    // Input beat
    assign out_free          = !r_ov || o_result_ch.ready;
    assign in_rdy            = (r_state == ST_IDLE) && out_free;
    assign i_sample_ch.ready = in_rdy;
    assign acc               = i_sample_ch.valid && in_rdy;
    assign smp_ext           = {{SAMPLE_BITS{1'b0}}, i_sample_ch.sample};
    assign smp_k             = smp_ext[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_fill  <= '0;
            r_phase <= '0;
        end else if (acc) begin
            r_wptr <= (r_wptr == IW'(WINDOW_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (r_fill != FW'(WINDOW_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
            r_phase <= (r_phase == PW'(ANALYSIS_PERIOD - 1)) ? '0 : r_phase + 1'b1;
        end
    end

    // Window address mapping: logical index 0 is the oldest entry
    assign idx_b  = {1'b0, r_idx} + (IW+1)'(2);
    assign sum_a  = {1'b0, r_wptr} + {1'b0, r_idx};
    assign sum_b  = {1'b0, r_wptr} + idx_b;
    assign addr_a = (sum_a >= (IW+1)'(WINDOW_DEPTH)) ?
                    IW'(sum_a - (IW+1)'(WINDOW_DEPTH)) : sum_a[IW-1:0];
    assign addr_b = (sum_b >= (IW+1)'(WINDOW_DEPTH)) ?
                    IW'(sum_b - (IW+1)'(WINDOW_DEPTH)) : sum_b[IW-1:0];
    assign val_a  = (LW'(r_idx) + LW'(r_fill)) >= LW'(WINDOW_DEPTH);
    assign val_b  = (LW'(idx_b) + LW'(r_fill)) >= LW'(WINDOW_DEPTH);

    assign limit    = (r_mode == MD_FIND1) ? IW'(FIRST_LIMIT) : IW'(SCAN_LIMIT);
    assign at_limit = (r_idx >= limit);
    assign rd_en    = (r_state == ST_RD) && !at_limit;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mem[r_wptr] <= smp_k;
        end
        if (rd_en) begin
            r_a  <= r_mem[addr_a];
            r_b  <= r_mem[addr_b];
            r_av <= val_a;
            r_bv <= val_b;
        end
    end

    // Edge evaluation
    assign a_s   = signed'(CW'(r_av ? r_a : '0));
    assign b_s   = signed'(CW'(r_bv ? r_b : '0));
    assign rise  = b_s - a_s;
    assign thr_s = signed'(CW'(r_thr));
    assign go_on = (r_mode == MD_SKIP1 || r_mode == MD_SKIP2) ? (rise > 0) : (rise < thr_s);

    assign last_sum   = LW'(r_idx) + LW'(r_gap);
    assign last_clamp = (last_sum > LW'(SCAN_LIMIT)) ? IW'(SCAN_LIMIT) : last_sum[IW-1:0];
    assign edge_dist  = r_idx - r_first;

    prwd_divider #(
        .DEN_BITS (IW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_numer  (r_num),
        .i_denom  (edge_dist),
        .o_status (div_st),
        .o_quot   (div_quot)
    );

    always_comb begin
        logic scan_end;
        n_state   = r_state;
        n_mode    = r_mode;
        n_idx     = r_idx;
        n_first   = r_first;
        n_held    = r_held;
        n_ov      = r_ov && !o_result_ch.ready;
        n_o_rate  = r_o_rate;
        n_o_upd   = r_o_upd;
        div_start = 1'b0;
        scan_end  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (r_phase == '0) begin
                        n_state = ST_RD;
                        n_mode  = MD_SKIP1;
                        n_idx   = '0;
                    end else begin
                        n_ov     = 1'b1;
                        n_o_rate = r_held;
                        n_o_upd  = 1'b0;
                    end
                end
            end
            ST_RD: begin
                if (at_limit) begin
                    scan_end = 1'b1;
                end else begin
                    n_state = ST_EV;
                end
            end
            ST_EV: begin
                if (go_on) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_RD;
                end else begin
                    scan_end = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    n_held  = div_quot;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_ov     = 1'b1;
                    n_o_rate = r_held;
                    n_o_upd  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Advance the scan to its next leg, or end it after the last leg
        if (scan_end) begin
            case (r_mode)
                MD_SKIP1: begin
                    n_mode  = MD_FIND1;
                    n_state = ST_RD;
                end
                MD_FIND1: begin
                    n_first = r_idx;
                    n_idx   = last_clamp;
                    n_mode  = MD_SKIP2;
                    n_state = ST_RD;
                end
                MD_SKIP2: begin
                    n_mode  = MD_FIND2;
                    n_state = ST_RD;
                end
                default: begin
                    if (edge_dist == '0) begin
                        n_held  = '0;
                        n_state = ST_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MD_SKIP1;
            r_idx   <= '0;
            r_first <= '0;
            r_held  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_idx   <= n_idx;
            r_first <= n_first;
            r_held  <= n_held;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_rate <= n_o_rate;
        r_o_upd  <= n_o_upd;
    end

    assign o_result_ch.valid        = r_ov;
    assign o_result_ch.pulse_rate   = r_o_rate;
    assign o_result_ch.rate_updated = r_o_upd;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_div_busy_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DIV) |-> !div_st.busy)
        else $error("divider busy outside the divide state");

    a_plain_beat_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (r_phase != '0)) |=> (r_ov && !r_o_upd))
        else $error("non-analysis beat did not yield a held-rate result");

    a_scan_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EV) |-> (r_idx < IW'(SCAN_LIMIT)))
        else $error("scan read past window");

endmodule

### test/tb_pulse_rate_window_detector.sv
// ----------------------------------------------------------------------------
// tb_pulse_rate_window_detector
// Self-checking bench for the pulse rate window detector.
// ----------------------------------------------------------------------------
// Sample beats go in over the valid/ready sample channel, and every beat is
// mirrored into a local model of the 64-entry window, the analysis phase and
// the held rate. The model scans the window on each analysis beat the way
// the block does, and its result waits in a queue until the block's result
// beat arrives. A short table of directed beats runs first. Random phases
// follow, each with its own register setting (the extremes among them) and
// one of four idling patterns. The random beats are mostly synthetic
// pulse trains, mixed with ramps, flat stretches and noise.
// ----------------------------------------------------------------------------
module tb_pulse_rate_window_detector;
    import prwd_pkg::*;

    localparam int WIN         = 64;
    localparam int PERIOD      = 32;
    localparam int SCAN_END    = WIN - 2;
    localparam int FIRST_END   = WIN - 13;
    localparam int N_PHASES    = 12;
    localparam int PHASE_BEATS = 152;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 300;
    localparam int MAX_PRINTS  = 40;

    // 1920 / (62 - 51): an all-zero window finds no edge before the limit
    localparam logic [RATE_BITS-1:0] RATE_AFTER_RESET = 16'd174;

    typedef struct packed {
        logic [RATE_BITS-1:0] rate;
        logic                 updated;
    } t_rate_beat;

    typedef struct packed {
        logic [IN_SAMPLE_BITS-1:0] smp;
        logic                      known;
        logic [RATE_BITS-1:0]      rate;
        logic                      upd;
    } t_dir_row;

    typedef enum int {
        WAVE_PULSE,
        WAVE_RAMP_UP,
        WAVE_RAMP_DOWN,
        WAVE_NOISE,
        WAVE_FLAT
    } t_wave_kind;

    localparam int N_DIR = 24;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{12'hFFF, 1'b1, RATE_AFTER_RESET, 1'b1},
        '{12'h000, 1'b1, RATE_AFTER_RESET, 1'b0},
        '{12'hFFF, 1'b1, RATE_AFTER_RESET, 1'b0},
        '{12'h800, 1'b0, 16'd0, 1'b0},
        '{12'h7FF, 1'b0, 16'd0, 1'b0},
        '{12'h001, 1'b0, 16'd0, 1'b0},
        '{12'hFFE, 1'b0, 16'd0, 1'b0},
        '{12'h555, 1'b0, 16'd0, 1'b0},
        '{12'hAAA, 1'b0, 16'd0, 1'b0},
        '{12'd100, 1'b0, 16'd0, 1'b0},
        '{12'd400, 1'b0, 16'd0, 1'b0},
        '{12'd900, 1'b0, 16'd0, 1'b0},
        '{12'd1500, 1'b0, 16'd0, 1'b0},
        '{12'd1200, 1'b0, 16'd0, 1'b0},
        '{12'd900, 1'b0, 16'd0, 1'b0},
        '{12'd600, 1'b0, 16'd0, 1'b0},
        '{12'd300, 1'b0, 16'd0, 1'b0},
        '{12'd100, 1'b0, 16'd0, 1'b0},
        '{12'd100, 1'b0, 16'd0, 1'b0},
        '{12'd600, 1'b0, 16'd0, 1'b0},
        '{12'd1300, 1'b0, 16'd0, 1'b0},
        '{12'd2000, 1'b0, 16'd0, 1'b0},
        '{12'd1600, 1'b0, 16'd0, 1'b0},
        '{12'd1100, 1'b0, 16'd0, 1'b0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr   = '0;
    logic [CFG_DATA_BITS-1:0] pwdata  = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    logic                      tx_valid  = 1'b0;
    logic [IN_SAMPLE_BITS-1:0] tx_sample = '0;
    logic                      tx_known  = 1'b0;
    logic [RATE_BITS-1:0]      tx_rate   = '0;
    logic                      tx_upd    = 1'b0;
    logic                      rx_ready  = 1'b0;

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int quiet_cycles  = 0;
    int err_count     = 0;
    int n_beats       = 0;
    int n_checked     = 0;
    int n_analyses    = 0;
    int n_zero_dist   = 0;
    int n_clamped     = 0;
    int n_settings    = 0;

    // local copy of the block's state and registers
    logic [IN_SAMPLE_BITS-1:0] hist [WIN];
    int                        beats_to_scan = 0;
    logic [RATE_BITS-1:0]      rate_held     = '0;
    logic [THR_BITS-1:0]       thr_reg       = RISE_THRESHOLD_RST;
    logic [NUM_BITS-1:0]       num_reg       = RATE_NUMERATOR_RST;
    logic [GAP_BITS-1:0]       gap_reg       = MIN_GAP_RST;

    t_rate_beat rate_due_q [$];

    t_wave_kind wave_kind = WAVE_NOISE;
    int wave_t     = 0;
    int wave_left  = 0;
    int wave_per   = 16;
    int wave_rise  = 2;
    int wave_amp   = 1000;
    int wave_base  = 0;
    int wave_noise = 0;
    int wave_level = 0;
    int wave_step  = 1;

    prwd_sample_if smp_ch ();
    prwd_result_if res_ch ();

    assign smp_ch.valid  = tx_valid;
    assign smp_ch.sample = tx_sample;
    assign res_ch.ready  = rx_ready;

    pulse_rate_window_detector u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (smp_ch),
        .o_result_ch (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < WIN; i++) begin
            hist[i] = '0;
        end
    end

    function automatic int rise_at(int i);
        return int'(hist[i+2]) - int'(hist[i]);
    endfunction

    function automatic int skip_rising(int i, int lim);
        while (i < lim && rise_at(i) > 0) begin
            i++;
        end
        return i;
    endfunction

    function automatic int find_edge(int i, int lim);
        while (i < lim && rise_at(i) < int'(thr_reg)) begin
            i++;
        end
        return i;
    endfunction

    function automatic logic [RATE_BITS-1:0] scan_rate();
        int first;
        int last;
        int span;
        first = skip_rising(0, SCAN_END);
        first = find_edge(first, FIRST_END);
        last  = first + int'(gap_reg);
        if (last > SCAN_END) begin
            last = SCAN_END;
            n_clamped++;
        end
        last = skip_rising(last, SCAN_END);
        last = find_edge(last, SCAN_END);
        span = last - first;
        if (span == 0) begin
            n_zero_dist++;
            return '0;
        end
        return RATE_BITS'(int'(num_reg) / span);
    endfunction

    function automatic t_rate_beat rate_after_beat(logic [IN_SAMPLE_BITS-1:0] smp);
        t_rate_beat res;
        for (int i = 0; i < WIN - 1; i++) begin
            hist[i] = hist[i+1];
        end
        hist[WIN-1] = smp;
        res.updated = 1'b0;
        if (beats_to_scan == 0) begin
            rate_held   = scan_rate();
            res.updated = 1'b1;
            n_analyses++;
        end
        beats_to_scan = (beats_to_scan == PERIOD - 1) ? 0 : beats_to_scan + 1;
        res.rate = rate_held;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS) begin
            $display("MISMATCH @%0t %s: got %0d, want %0d", $realtime, what, got, want);
        end
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_rate_beat due;
        t_rate_beat pred;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (rate_due_q.size() == 0) begin
                    report_mismatch("result beat with none pending", res_ch.pulse_rate, -1);
                end else begin
                    due = rate_due_q.pop_front();
                    if (res_ch.pulse_rate !== due.rate) begin
                        report_mismatch("pulse_rate", res_ch.pulse_rate, due.rate);
                    end
                    if (res_ch.rate_updated !== due.updated) begin
                        report_mismatch("rate_updated", res_ch.rate_updated, due.updated);
                    end
                    n_checked++;
                end
            end
            if (smp_ch.valid && smp_ch.ready) begin
                pred = rate_after_beat(smp_ch.sample);
                if (tx_known) begin
                    pred.rate    = tx_rate;
                    pred.updated = tx_upd;
                end
                rate_due_q.push_back(pred);
                n_beats++;
            end
        end
    end

    always @(posedge i_clk) begin
        rx_ready <= i_rst_n && ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("tb_pulse_rate_window_detector: done, errors");
        $finish;
    end

    task automatic apb_access(input logic wr, input logic [REG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] wdata,
                              output logic [CFG_DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_BITS'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        logic [CFG_DATA_BITS-1:0] rd;
        apb_access(1'b1, idx, val, rd);
        apb_access(1'b0, idx, '0, rd);
        if (rd !== val) begin
            report_mismatch($sformatf("readback of register %0d", idx), rd, val);
        end
    endtask

    task automatic set_config(input logic [THR_BITS-1:0] thr, input logic [NUM_BITS-1:0] num,
                              input logic [GAP_BITS-1:0] gap);
        write_reg(REG_RISE_THRESHOLD, CFG_DATA_BITS'(thr));
        write_reg(REG_RATE_NUMERATOR, CFG_DATA_BITS'(num));
        write_reg(REG_MIN_GAP, CFG_DATA_BITS'(gap));
        thr_reg = thr;
        num_reg = num;
        gap_reg = gap;
        n_settings++;
    endtask

    task automatic send_sample(input logic [IN_SAMPLE_BITS-1:0] smp, input logic known,
                               input logic [RATE_BITS-1:0] rate, input logic upd);
        while ($urandom_range(99) < send_idle_pct) begin
            tx_valid <= 1'b0;
            @(posedge i_clk);
        end
        tx_valid  <= 1'b1;
        tx_sample <= smp;
        tx_known  <= known;
        tx_rate   <= rate;
        tx_upd    <= upd;
        do @(posedge i_clk); while (!smp_ch.ready);
    endtask

    task automatic pick_wave();
        int r;
        r          = $urandom_range(99);
        wave_t     = 0;
        wave_left  = $urandom_range(40, 110);
        wave_per   = $urandom_range(10, 45);
        wave_rise  = $urandom_range(1, 6);
        wave_amp   = $urandom_range(50, 3800);
        wave_base  = $urandom_range(0, 4095 - wave_amp);
        wave_noise = ($urandom_range(99) < 40) ? 0 : $urandom_range(1, 80);
        wave_step  = $urandom_range(1, 60);
        if (r < 62) begin
            wave_kind = WAVE_PULSE;
        end else if (r < 72) begin
            wave_kind  = WAVE_RAMP_UP;
            wave_level = $urandom_range(0, 1000);
        end else if (r < 78) begin
            wave_kind  = WAVE_RAMP_DOWN;
            wave_level = $urandom_range(3000, 4095);
        end else if (r < 90) begin
            wave_kind = WAVE_NOISE;
        end else begin
            wave_kind = WAVE_FLAT;
            case ($urandom_range(2))
                0: wave_level = 0;
                1: wave_level = 4095;
                default: wave_level = $urandom_range(0, 4095);
            endcase
        end
    endtask

    function automatic logic [IN_SAMPLE_BITS-1:0] next_wave_sample();
        int v;
        int ph;
        case (wave_kind)
            WAVE_PULSE: begin
                ph = wave_t % wave_per;
                if (ph < wave_rise) begin
                    v = wave_base + wave_amp * ph / wave_rise;
                end else begin
                    v = wave_base + wave_amp
                        - wave_amp * (ph - wave_rise) / (wave_per - wave_rise);
                end
                v = v + int'($urandom_range(0, 2 * wave_noise)) - wave_noise;
            end
            WAVE_RAMP_UP:   v = wave_level + wave_step * wave_t;
            WAVE_RAMP_DOWN: v = wave_level - wave_step * wave_t;
            WAVE_NOISE:     v = $urandom_range(0, 4095);
            default:        v = wave_level;
        endcase
        wave_t++;
        if (v < 0) begin
            v = 0;
        end else if (v > 4095) begin
            v = 4095;
        end
        return IN_SAMPLE_BITS'(v);
    endfunction

    task automatic drain();
        tx_valid <= 1'b0;
        do @(posedge i_clk); while (rate_due_q.size() != 0);
    endtask

    task automatic run_phase(input int idx);
        logic [THR_BITS-1:0] thr;
        drain();
        case (idx)
            0: set_config(RISE_THRESHOLD_RST, RATE_NUMERATOR_RST, MIN_GAP_RST);
            1: set_config(12'd0, 16'hFFFF, 6'd0);
            2: set_config(12'hFFF, 16'd1, 6'h3F);
            3: set_config(12'd200, 16'hFFFF, 6'd50);
            4: set_config(12'd1, 16'd1920, 6'd1);
            5: set_config(12'd123, 16'd0, 6'd62);
            default: begin
                thr = ($urandom_range(99) < 15) ? THR_BITS'($urandom_range(0, 4095))
                                                : THR_BITS'($urandom_range(30, 700));
                set_config(thr, NUM_BITS'($urandom_range(1, 65535)),
                           GAP_BITS'($urandom_range(0, 63)));
            end
        endcase
        case (idx % 4)
            0: begin
                send_idle_pct = 0;
                rx_stall_pct  = 0;
            end
            1: begin
                send_idle_pct = 61;
                rx_stall_pct  = 0;
            end
            2: begin
                send_idle_pct = 0;
                rx_stall_pct  = 61;
            end
            default: begin
                send_idle_pct = 30;
                rx_stall_pct  = 30;
            end
        endcase
        for (int k = 0; k < PHASE_BEATS; k++) begin
            if (wave_left == 0) begin
                pick_wave();
            end
            wave_left--;
            send_sample(next_wave_sample(), 1'b0, '0, 1'b0);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            send_sample(DIR_ROWS[i].smp, DIR_ROWS[i].known, DIR_ROWS[i].rate,
                        DIR_ROWS[i].upd);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            run_phase(p);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("summary: %0d sample beats, %0d results checked, %0d register settings",
                 n_beats, n_checked, n_settings);
        $display("summary: %0d analyses, %0d with zero edge distance, %0d end edges clamped",
                 n_analyses, n_zero_dist, n_clamped);
        if (err_count == 0 && rate_due_q.size() == 0) begin
            $display("tb_pulse_rate_window_detector: done, clean");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, rate_due_q.size());
            $display("tb_pulse_rate_window_detector: done, errors");
        end
        $finish;
    end

endmodule
